FILE: src/kmp_pkg.sv
`timescale 1ns / 1ps
// kmp_pkg: operation codes, field widths and the result record shared by the
// stream matcher sequencer and its top level. No dependencies.

package kmp_pkg;

   localparam int OP_W     = 2;
   localparam int SYM_W    = 8;
   localparam int MLEN_W   = 7;
   localparam int TPOS_W   = 32;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;

   typedef struct packed {
      logic              match;
      logic [TPOS_W-1:0] match_start;
      logic [MLEN_W-1:0] matched_length;
      logic              overflow;
   } kmp_result_type;

endpackage

FILE: src/kmp_tables.sv
`timescale 1ns / 1ps
// kmp_tables: pattern byte store and failure (prefix-function) table, each a
// single-write, single-read memory with registered read data. Uses kmp_pkg.

module kmp_tables
   import kmp_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              pat_we,
   input  logic [ADDR_W-1:0] pat_waddr,
   input  logic [SYM_W-1:0]  pat_wdata,
   input  logic [ADDR_W-1:0] pat_raddr,
   output logic [SYM_W-1:0]  pat_rdata,
   input  logic              fail_we,
   input  logic [ADDR_W-1:0] fail_waddr,
   input  logic [ADDR_W-1:0] fail_wdata,
   input  logic [ADDR_W-1:0] fail_raddr,
   output logic [ADDR_W-1:0] fail_rdata
);

   logic [SYM_W-1:0]  pat_mem  [DEPTH];
   logic [ADDR_W-1:0] fail_mem [DEPTH];
   logic [SYM_W-1:0]  pat_rd_ff;
   logic [ADDR_W-1:0] fail_rd_ff;

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= pat_wdata;
      end
      pat_rd_ff <= pat_mem[pat_raddr];
   end

   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[fail_waddr] <= fail_wdata;
      end
      fail_rd_ff <= fail_mem[fail_raddr];
   end

   assign pat_rdata  = pat_rd_ff;
   assign fail_rdata = fail_rd_ff;

endmodule

FILE: src/kmp_ctrl.sv
`timescale 1ns / 1ps
// kmp_ctrl: sequencer that walks the failure chain one compare per cycle for
// both pattern appends and text bytes. Uses kmp_pkg; drives kmp_tables.

module kmp_ctrl
   import kmp_pkg::*;
#(
   parameter int MAX_PATTERN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [SYM_W-1:0]     req_symbol,
   output logic                 done_valid,
   input  logic                 done_ready,
   output kmp_result_type       done_result,
   output logic                 pat_we,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_waddr,
   output logic [SYM_W-1:0]     pat_wdata,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_raddr,
   input  logic [SYM_W-1:0]     pat_rdata,
   output logic                 fail_we,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_waddr,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_wdata,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_raddr,
   input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_rdata
);

   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [LEN_W-1:0]  j_ff, j_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [LEN_W-1:0]  tml_ff, tml_in;
   logic [TPOS_W-1:0] tpos_ff, tpos_in;
   kmp_result_type    res_ff, res_in;

   logic              accept;
   logic              full;
   logic              hit;
   logic [LEN_W-1:0]  jr;
   logic [LEN_W-1:0]  tml_dec;
   logic [LEN_W-1:0]  plen_dec;
   logic [ADDR_W-1:0] frd_dec;
   logic [ADDR_W-1:0] tml_prev_addr;
   logic [ADDR_W-1:0] plen_prev_addr;
   logic [ADDR_W-1:0] frd_prev_addr;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign done_valid  = (state_ff == ST_DONE);
   assign done_result = res_ff;

   assign full = (plen_ff == LEN_W'(MAX_PATTERN));
   assign hit  = (pat_rdata == sym_ff);
   assign jr   = hit ? (j_ff + LEN_W'(1)) : '0;

   // Entry below a prefix length; clamp the empty case to entry zero.
   assign tml_dec        = tml_ff - LEN_W'(1);
   assign plen_dec       = plen_ff - LEN_W'(1);
   assign frd_dec        = fail_rdata - ADDR_W'(1);
   assign tml_prev_addr  = (tml_ff == '0) ? '0 : tml_dec[ADDR_W-1:0];
   assign plen_prev_addr = (plen_ff == '0) ? '0 : plen_dec[ADDR_W-1:0];
   assign frd_prev_addr  = (fail_rdata == '0) ? '0 : frd_dec;

   // Read addresses: probe pattern[j] and failure[j-1] for the next compare.
   always_comb begin
      pat_raddr  = tml_ff[ADDR_W-1:0];
      fail_raddr = plen_prev_addr;
      case (state_ff)
         ST_IDLE: begin
            pat_raddr = tml_ff[ADDR_W-1:0];
            if ((req_op == OP_TEXT) && (tml_ff != plen_ff)) begin
               fail_raddr = tml_prev_addr;
            end else begin
               fail_raddr = plen_prev_addr;
            end
         end
         ST_LOAD, ST_CMP: begin
            pat_raddr  = fail_rdata;
            fail_raddr = frd_prev_addr;
         end
         default: begin
            pat_raddr  = tml_ff[ADDR_W-1:0];
            fail_raddr = plen_prev_addr;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      sym_in     = sym_ff;
      j_in       = j_ff;
      plen_in    = plen_ff;
      tml_in     = tml_ff;
      tpos_in    = tpos_ff;
      res_in     = res_ff;
      pat_we     = 1'b0;
      pat_waddr  = plen_ff[ADDR_W-1:0];
      pat_wdata  = req_symbol;
      fail_we    = 1'b0;
      fail_waddr = plen_ff[ADDR_W-1:0];
      fail_wdata = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               sym_in   = req_symbol;
               res_in   = '0;
               state_in = ST_DONE;
               case (req_op)
                  OP_CLEAR: begin
                     plen_in = '0;
                     tml_in  = '0;
                     tpos_in = '0;
                  end
                  OP_APPEND: begin
                     if (full) begin
                        res_in.overflow = 1'b1;
                     end else begin
                        pat_we = 1'b1;
                        if (plen_ff == '0) begin
                           fail_we = 1'b1;
                           plen_in = LEN_W'(1);
                        end else begin
                           state_in = ST_LOAD;
                        end
                     end
                  end
                  OP_TEXT: begin
                     if (plen_ff == '0) begin
                        res_in.match       = 1'b1;
                        res_in.match_start = tpos_ff + TPOS_W'(1);
                        tml_in             = '0;
                        tpos_in            = tpos_ff + TPOS_W'(1);
                     end else if (tml_ff == plen_ff) begin
                        state_in = ST_LOAD;
                     end else begin
                        j_in     = tml_ff;
                        state_in = ST_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            j_in     = LEN_W'(fail_rdata);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (hit || (j_ff == '0)) begin
               res_in.matched_length = MLEN_W'(jr);
               state_in              = ST_DONE;
               if (op_ff == OP_APPEND) begin
                  fail_we    = 1'b1;
                  fail_wdata = jr[ADDR_W-1:0];
                  plen_in    = plen_ff + LEN_W'(1);
               end else begin
                  tml_in  = jr;
                  tpos_in = tpos_ff + TPOS_W'(1);
                  if (jr == plen_ff) begin
                     res_in.match       = 1'b1;
                     res_in.match_start = tpos_ff - TPOS_W'(plen_ff) + TPOS_W'(1);
                  end
               end
            end else begin
               // Fall back through the failure entry and probe again.
               j_in = LEN_W'(fail_rdata);
            end
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         plen_ff  <= '0;
         tml_ff   <= '0;
         tpos_ff  <= '0;
      end else begin
         state_ff <= state_in;
         plen_ff  <= plen_in;
         tml_ff   <= tml_in;
         tpos_ff  <= tpos_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      sym_ff <= sym_in;
      j_ff   <= j_in;
      res_ff <= res_in;
   end

`ifndef SYNTH
   a_tml_bounded: assert property (@(posedge clock) disable iff (reset)
      tml_ff <= plen_ff)
      else $error("text match length exceeds pattern length");

   a_plen_bounded: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length exceeds capacity");

   a_probe_in_pattern: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (j_ff < plen_ff))
      else $error("compare probes beyond the stored pattern");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_CLEAR)) |=> ((tpos_ff == '0) && (plen_ff == '0)))
      else $error("clear did not reset pattern and text position");
`endif

endmodule

FILE: src/kmp_stream_matcher.sv
`timescale 1ns / 1ps
// Clear, refused append, first pattern byte, unused op and any text byte on an
// empty pattern go straight to the result; other appends and text bytes walk
// the failure chain after a load step if it starts from the last failure
// entry, one table probe per cycle. One transaction at a time: no request is
// taken until the result moves to the output register. Synchronous reset
// empties the pattern, zeroes match length and text position; tables keep data.

module kmp_stream_matcher
   import kmp_pkg::*;
#(
   parameter int MAX_PATTERN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_op,
   input  logic [SYM_W-1:0]  req_symbol,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_match,
   output logic [TPOS_W-1:0] rsp_match_start,
   output logic [MLEN_W-1:0] rsp_matched_length,
   output logic              rsp_overflow
);

   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic              done_valid;
   logic              done_ready;
   kmp_result_type    done_result;
   logic              pat_we;
   logic [ADDR_W-1:0] pat_waddr;
   logic [SYM_W-1:0]  pat_wdata;
   logic [ADDR_W-1:0] pat_raddr;
   logic [SYM_W-1:0]  pat_rdata;
   logic              fail_we;
   logic [ADDR_W-1:0] fail_waddr;
   logic [ADDR_W-1:0] fail_wdata;
   logic [ADDR_W-1:0] fail_raddr;
   logic [ADDR_W-1:0] fail_rdata;

   logic              rsp_valid_ff, rsp_valid_in;
   kmp_result_type    rsp_data_ff, rsp_data_in;

   kmp_ctrl #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_symbol  (req_symbol),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_result (done_result),
      .pat_we      (pat_we),
      .pat_waddr   (pat_waddr),
      .pat_wdata   (pat_wdata),
      .pat_raddr   (pat_raddr),
      .pat_rdata   (pat_rdata),
      .fail_we     (fail_we),
      .fail_waddr  (fail_waddr),
      .fail_wdata  (fail_wdata),
      .fail_raddr  (fail_raddr),
      .fail_rdata  (fail_rdata)
   );

   kmp_tables #(
      .DEPTH  (MAX_PATTERN),
      .ADDR_W (ADDR_W)
   ) u_tables (
      .clock      (clock),
      .pat_we     (pat_we),
      .pat_waddr  (pat_waddr),
      .pat_wdata  (pat_wdata),
      .pat_raddr  (pat_raddr),
      .pat_rdata  (pat_rdata),
      .fail_we    (fail_we),
      .fail_waddr (fail_waddr),
      .fail_wdata (fail_wdata),
      .fail_raddr (fail_raddr),
      .fail_rdata (fail_rdata)
   );

   // Output register: load when empty or being drained this cycle.
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match          = rsp_data_ff.match;
   assign rsp_match_start    = rsp_data_ff.match_start;
   assign rsp_matched_length = rsp_data_ff.matched_length;
   assign rsp_overflow       = rsp_data_ff.overflow;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for kmp_stream_matcher. Needs kmp_pkg and the
// matcher RTL; carries its own prefix-function predictor of every result.

module testbench
   import kmp_pkg::*;
();

   localparam int PATTERN_DEPTH = 64;
   localparam int STALL_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 120;
   localparam int PHASE_ITEMS   = 50;

   // op value with no defined operation
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SYM_W-1:0] symbol;
   } request_item_type;

   typedef enum int {PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH} idle_phase_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_op = OP_CLEAR;
   logic [SYM_W-1:0]  req_symbol = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_match;
   logic [TPOS_W-1:0] rsp_match_start;
   logic [MLEN_W-1:0] rsp_matched_length;
   logic              rsp_overflow;

   request_item_type pending_requests[$];
   kmp_result_type   expected_results[$];

   // predictor state
   logic [SYM_W-1:0]  pat_bytes[PATTERN_DEPTH];
   logic [MLEN_W-1:0] fail_len[PATTERN_DEPTH];
   int                pat_len = 0;
   int                text_len = 0;
   logic [TPOS_W-1:0] text_idx = '0;

   int  requests_sent = 0;
   int  responses_checked = 0;
   int  matches_seen = 0;
   int  refusals_seen = 0;
   int  error_count = 0;
   int  quiet_cycles = 0;
   int  hold_cycles = 0;
   logic holding = 1'b0;
   logic hold_done = 1'b0;
   idle_phase_type idle_phase;
   int  idle_pct;
   int  stall_pct;

   kmp_stream_matcher #(.MAX_PATTERN(PATTERN_DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match         (rsp_match),
      .rsp_match_start   (rsp_match_start),
      .rsp_matched_length(rsp_matched_length),
      .rsp_overflow      (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Prefix-function matcher: update state for one transaction, return its result.
   function automatic kmp_result_type predict_result(input logic [OP_W-1:0] op,
                                                     input logic [SYM_W-1:0] sym);
      kmp_result_type res;
      int j;
      res = '0;
      j = 0;
      case (op)
         OP_CLEAR: begin
            pat_len = 0;
            text_len = 0;
            text_idx = '0;
         end
         OP_APPEND: begin
            if (pat_len >= PATTERN_DEPTH) begin
               res.overflow = 1'b1;
            end else begin
               pat_bytes[pat_len] = sym;
               if (pat_len > 0) begin
                  j = int'(fail_len[pat_len - 1]);
                  while (j > 0 && pat_bytes[j] != sym)
                     j = int'(fail_len[j - 1]);
                  if (pat_bytes[j] == sym)
                     j++;
               end
               fail_len[pat_len] = j[MLEN_W-1:0];
               pat_len++;
               res.matched_length = j[MLEN_W-1:0];
            end
         end
         OP_TEXT: begin
            if (pat_len == 0) begin
               res.match = 1'b1;
               res.match_start = text_idx + TPOS_W'(1);
               text_len = 0;
            end else begin
               j = text_len;
               // after a full match, restart from the last failure entry
               if (j >= pat_len)
                  j = int'(fail_len[pat_len - 1]);
               while (j > 0 && j < PATTERN_DEPTH && pat_bytes[j] != sym)
                  j = int'(fail_len[j - 1]);
               if (j < PATTERN_DEPTH && pat_bytes[j] == sym)
                  j++;
               text_len = j;
               res.matched_length = j[MLEN_W-1:0];
               if (j == pat_len) begin
                  res.match = 1'b1;
                  res.match_start = text_idx - TPOS_W'(pat_len) + TPOS_W'(1);
               end
            end
            text_idx = text_idx + TPOS_W'(1);
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic add_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
      request_item_type item;
      item.op = op;
      item.symbol = sym;
      pending_requests.insert(pending_requests.size(), item);
   endtask

   task automatic check_field(input string name, input logic [TPOS_W-1:0] want,
                              input logic [TPOS_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always_comb begin
      idle_phase = idle_phase_type'((requests_sent / PHASE_ITEMS) % 4);
      case (idle_phase)
         PH_STEADY:         begin idle_pct = 0;  stall_pct = 0;  end
         PH_SENDER_IDLE:    begin idle_pct = 72; stall_pct = 0;  end
         PH_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 72; end
         default:           begin idle_pct = 16; stall_pct = 16; end
      endcase
   end

   // driver
   always @(posedge clock) begin
      request_item_type next_req;
      logic fired;
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fired = req_valid && req_ready;
         if (fired) begin
            expected_results.insert(expected_results.size(),
                                    predict_result(req_op, req_symbol));
            requests_sent <= requests_sent + 1;
         end
         if (fired || !req_valid) begin
            offer = pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct;
            if (offer) begin
               next_req = pending_requests.pop_front();
               req_op <= next_req.op;
               req_symbol <= next_req.symbol;
            end
            req_valid <= offer;
         end
      end
   end

   // long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (!reset && !hold_done) begin
         if (holding) begin
            if (hold_cycles == HOLD_CYCLES - 1) begin
               holding <= 1'b0;
               hold_done <= 1'b1;
            end
            hold_cycles <= hold_cycles + 1;
         end else if (requests_sent >= HOLD_AFTER) begin
            holding <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      kmp_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %0b %h %0d %0b",
                        $time, rsp_match, rsp_match_start, rsp_matched_length,
                        rsp_overflow);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("match", TPOS_W'(want.match), TPOS_W'(rsp_match));
               check_field("match_start", want.match_start, rsp_match_start);
               check_field("matched_length", TPOS_W'(want.matched_length),
                           TPOS_W'(rsp_matched_length));
               check_field("overflow", TPOS_W'(want.overflow), TPOS_W'(rsp_overflow));
            end
            responses_checked++;
            if (rsp_match)
               matches_seen++;
            if (rsp_overflow)
               refusals_seen++;
         end
         rsp_ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("kmp_stream_matcher: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [SYM_W-1:0] alpha[3];
      logic [SYM_W-1:0] pat[16];
      int n_alpha;
      int plen;
      int tlen;
      int roll;
      logic long_done;
      long_done = 1'b0;

      // directed: empty pattern, unused op, zero/ones bytes, overlaps, append after text
      add_request(OP_TEXT, 8'h00);
      add_request(OP_TEXT, 8'hFF);
      add_request(OP_UNUSED, 8'hA5);
      add_request(OP_CLEAR, 8'h00);
      add_request(OP_APPEND, 8'h00);
      add_request(OP_APPEND, 8'h00);
      add_request(OP_APPEND, 8'hFF);
      add_request(OP_TEXT, 8'h00);
      add_request(OP_TEXT, 8'h00);
      add_request(OP_TEXT, 8'h00);
      add_request(OP_TEXT, 8'hFF);
      add_request(OP_TEXT, 8'h00);
      add_request(OP_TEXT, 8'h00);
      add_request(OP_TEXT, 8'hFF);
      add_request(OP_APPEND, 8'h00);
      add_request(OP_TEXT, 8'h00);
      add_request(OP_UNUSED, 8'hFF);
      add_request(OP_CLEAR, 8'hFF);
      add_request(OP_TEXT, 8'h5A);
      add_request(OP_APPEND, 8'hFF);
      add_request(OP_TEXT, 8'hFF);

      while (pending_requests.size() < 420) begin
         roll = $urandom_range(0, 99);
         if (!long_done && pending_requests.size() >= 170) begin
            // fill the store with one repeated byte, overrun it, then walk the full chain
            alpha[0] = SYM_W'($urandom_range(0, 255));
            alpha[1] = alpha[0] ^ (8'h01 << $urandom_range(0, 7));
            add_request(OP_CLEAR, SYM_W'($urandom_range(0, 255)));
            repeat (PATTERN_DEPTH) add_request(OP_APPEND, alpha[0]);
            repeat (2) add_request(OP_APPEND, SYM_W'($urandom_range(0, 255)));
            repeat (70) add_request(OP_TEXT, alpha[0]);
            add_request(OP_TEXT, alpha[1]);
            repeat (5) add_request(OP_TEXT, alpha[0]);
            long_done = 1'b1;
         end else if (roll < 75) begin
            n_alpha = $urandom_range(2, 3);
            for (int k = 0; k < n_alpha; k++)
               alpha[k] = SYM_W'($urandom_range(0, 255));
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
            if ($urandom_range(0, 3) != 0)
               add_request(OP_CLEAR, SYM_W'($urandom_range(0, 255)));
            for (int k = 0; k < plen; k++) begin
               pat[k] = alpha[$urandom_range(0, n_alpha - 1)];
               add_request(OP_APPEND, pat[k]);
            end
            tlen = $urandom_range(6, 20);
            for (int k = 0; k < tlen; k++) begin
               if ($urandom_range(0, 4) == 0) begin
                  for (int m = 0; m < plen; m++)
                     add_request(OP_TEXT, pat[m]);
               end else begin
                  add_request(OP_TEXT, alpha[$urandom_range(0, n_alpha - 1)]);
               end
            end
            if ($urandom_range(0, 2) == 0) begin
               add_request(OP_APPEND, alpha[$urandom_range(0, n_alpha - 1)]);
               repeat ($urandom_range(4, 10))
                  add_request(OP_TEXT, alpha[$urandom_range(0, n_alpha - 1)]);
            end
         end else begin
            repeat ($urandom_range(1, 6))
               add_request(OP_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests across all idle phases and one long receiver hold-off;",
               requests_sent);
      $display("checked %0d responses, %0d with a match, %0d refused appends.",
               responses_checked, matches_seen, refusals_seen);
      if (error_count == 0) begin
         $display("kmp_stream_matcher: match");
      end else begin
         $display("kmp_stream_matcher: mismatch");
      end
      $finish;
   end

endmodule

FILE: kmp_stream_matcher.f
src/kmp_pkg.sv
src/kmp_tables.sv
src/kmp_ctrl.sv
src/kmp_stream_matcher.sv
test/testbench.sv
